// File: rtl/fcfl_pkg.sv
// ----------------------------------------------------------------------------
// fcfl_pkg
// Shared types and constants of the fixed-chunk free-list allocator.
// ----------------------------------------------------------------------------
package fcfl_pkg;

  localparam int MAX_CHUNKS   = 1024;
  localparam int IDX_W        = $clog2(MAX_CHUNKS);
  localparam int CNT_W        = $clog2(MAX_CHUNKS + 1);
  localparam int OP_W         = 2;
  localparam int STATUS_W     = 2;
  localparam int BYTES_W      = 17;
  localparam int ADDR_W       = 32;
  localparam int USE_BYTES_W  = 27;
  localparam int PROD_W       = IDX_W + BYTES_W;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  localparam logic [CNT_W-1:0]   RST_CHUNK_COUNT  = CNT_W'(1024);
  localparam logic [BYTES_W-1:0] RST_CHUNK_BYTES  = BYTES_W'(64);
  localparam logic [ADDR_W-1:0]  RST_BASE_ADDRESS = '0;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC    = 2'd0,
    OP_FREE     = 2'd1,
    OP_FREE_ALL = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_CHUNK   = 2'd1,
    ST_FREE_EMPTY = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHUNK_COUNT  = 2'd0,
    CFG_CHUNK_BYTES  = 2'd1,
    CFG_BASE_ADDRESS = 2'd2
  } cfg_reg_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic finish;
  } cmd_t;

endpackage

// File: rtl/fcfl_in_if.sv
// ----------------------------------------------------------------------------
// fcfl_in_if
// Request channel: opcode and chunk index with valid/ready.
// ----------------------------------------------------------------------------
interface fcfl_in_if;
  logic                          valid;
  logic                          ready;
  logic [fcfl_pkg::OP_W-1:0]     opcode;
  logic [fcfl_pkg::IDX_W-1:0]    chunk_index;

  modport source (output valid, output opcode, output chunk_index, input ready);
  modport sink   (input valid, input opcode, input chunk_index, output ready);
endinterface

// File: rtl/fcfl_out_if.sv
// ----------------------------------------------------------------------------
// fcfl_out_if
// Result channel: grant, status and usage counts with valid/ready.
// ----------------------------------------------------------------------------
interface fcfl_out_if;
  logic                              valid;
  logic                              ready;
  logic [fcfl_pkg::IDX_W-1:0]        granted_index;
  logic [fcfl_pkg::ADDR_W-1:0]       granted_address;
  logic [fcfl_pkg::STATUS_W-1:0]     status;
  logic [fcfl_pkg::CNT_W-1:0]        chunks_in_use;
  logic [fcfl_pkg::USE_BYTES_W-1:0]  bytes_in_use;

  modport source (output valid, output granted_index, output granted_address,
                  output status, output chunks_in_use, output bytes_in_use,
                  input ready);
  modport sink   (input valid, input granted_index, input granted_address,
                  input status, input chunks_in_use, input bytes_in_use,
                  output ready);
endinterface

// File: rtl/fcfl_cfg_if.sv
// ----------------------------------------------------------------------------
// fcfl_cfg_if
// Configuration write channel: register index and data with valid/ready.
// ----------------------------------------------------------------------------
interface fcfl_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [fcfl_pkg::CFG_IDX_W-1:0]    index;
  logic [fcfl_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/fcfl_ram.sv
// ----------------------------------------------------------------------------
// fcfl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fcfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/fcfl_ctrl.sv
// ----------------------------------------------------------------------------
// fcfl_ctrl
// Allocator controller: takes one request, then hands its result to the
// output register when that register is free.
// ----------------------------------------------------------------------------
module fcfl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output fcfl_pkg::cmd_t    cmd
);

  typedef enum logic {
    S_IDLE,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept, finish;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign finish   = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (finish) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign cmd.accept = accept;
  assign cmd.finish = finish;

endmodule

// File: rtl/fcfl_dp.sv
// ----------------------------------------------------------------------------
// fcfl_dp
// Allocator datapath: free-list state, link memory, configuration
// registers, products and the result register.
// ----------------------------------------------------------------------------
module fcfl_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  fcfl_pkg::cmd_t                       cmd,
  input  logic [fcfl_pkg::OP_W-1:0]            in_opcode,
  input  logic [fcfl_pkg::IDX_W-1:0]           in_chunk_index,
  input  logic                                 cfg_we,
  input  logic [fcfl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fcfl_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic [fcfl_pkg::IDX_W-1:0]           out_granted_index,
  output logic [fcfl_pkg::ADDR_W-1:0]          out_granted_address,
  output logic [fcfl_pkg::STATUS_W-1:0]        out_status,
  output logic [fcfl_pkg::CNT_W-1:0]           out_chunks_in_use,
  output logic [fcfl_pkg::USE_BYTES_W-1:0]     out_bytes_in_use
);

  localparam int IDX_W  = fcfl_pkg::IDX_W;
  localparam int CNT_W  = fcfl_pkg::CNT_W;
  localparam int PROD_W = fcfl_pkg::PROD_W;

  // configuration
  logic [CNT_W-1:0]                chunk_count_r;
  logic [fcfl_pkg::BYTES_W-1:0]    chunk_bytes_r;
  logic [fcfl_pkg::ADDR_W-1:0]     base_address_r;

  // free-list state
  logic [IDX_W-1:0] freed_head_r, freed_head_nxt;
  logic             freed_valid_r, freed_valid_nxt;
  logic [CNT_W-1:0] fresh_mark_r, fresh_mark_nxt;
  logic [CNT_W-1:0] in_use_r, in_use_nxt;
  logic             pop_r;

  // per-request results between accept and finish
  logic [IDX_W-1:0]                  g_index_r;
  logic                              granted_r;
  fcfl_pkg::status_t                 status_r;
  logic [PROD_W-1:0]                 addr_prod_r;
  logic [fcfl_pkg::USE_BYTES_W-1:0]  bytes_prod_r;

  // result register
  logic [IDX_W-1:0]                  res_index_r;
  logic [fcfl_pkg::ADDR_W-1:0]       res_addr_r;
  fcfl_pkg::status_t                 res_status_r;
  logic [CNT_W-1:0]                  res_chunks_r;
  logic [fcfl_pkg::USE_BYTES_W-1:0]  res_bytes_r;

  // combinational request decode
  logic [CNT_W-1:0]   pool_size;
  logic [IDX_W-1:0]   g_index;
  logic               granted;
  logic               pop;
  fcfl_pkg::status_t  status;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_rdata;
  logic [CNT_W+fcfl_pkg::BYTES_W-1:0] bytes_full;

  assign pool_size = (chunk_count_r > CNT_W'(fcfl_pkg::MAX_CHUNKS))
                   ? CNT_W'(fcfl_pkg::MAX_CHUNKS) : chunk_count_r;

  always_comb begin
    freed_head_nxt  = freed_head_r;
    freed_valid_nxt = freed_valid_r;
    fresh_mark_nxt  = fresh_mark_r;
    in_use_nxt      = in_use_r;
    g_index         = '0;
    granted         = 1'b0;
    pop             = 1'b0;
    status          = fcfl_pkg::ST_OK;
    ram_we          = 1'b0;
    case (in_opcode)
      fcfl_pkg::OP_ALLOC: begin
        if (freed_valid_r) begin
          // pop: the new head is loaded from the link memory read port at finish
          g_index = freed_head_r;
          granted = 1'b1;
          pop     = 1'b1;
        end else if (fresh_mark_r < pool_size) begin
          g_index        = fresh_mark_r[IDX_W-1:0];
          fresh_mark_nxt = fresh_mark_r + CNT_W'(1);
          granted        = 1'b1;
        end
        if (granted) begin
          if (in_use_r < CNT_W'(fcfl_pkg::MAX_CHUNKS)) begin
            in_use_nxt = in_use_r + CNT_W'(1);
          end
          freed_valid_nxt = freed_valid_r && (fresh_mark_nxt > in_use_nxt);
        end else begin
          status = fcfl_pkg::ST_NO_CHUNK;
        end
      end
      fcfl_pkg::OP_FREE: begin
        if (in_use_r == '0) begin
          status = fcfl_pkg::ST_FREE_EMPTY;
        end else begin
          ram_we          = 1'b1;
          freed_head_nxt  = in_chunk_index;
          freed_valid_nxt = 1'b1;
          in_use_nxt      = in_use_r - CNT_W'(1);
        end
      end
      fcfl_pkg::OP_FREE_ALL: begin
        freed_head_nxt  = '0;
        freed_valid_nxt = 1'b0;
        fresh_mark_nxt  = '0;
        in_use_nxt      = '0;
      end
      default: ;
    endcase
  end

  assign bytes_full = in_use_nxt * chunk_bytes_r;

  fcfl_ram #(
    .WIDTH (IDX_W),
    .DEPTH (fcfl_pkg::MAX_CHUNKS)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (cmd.accept && ram_we),
    .wr_addr (in_chunk_index),
    .wr_data (freed_head_r),
    .rd_en   (cmd.accept && pop),
    .rd_addr (freed_head_r),
    .rd_data (ram_rdata)
  );

  // configuration and list state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_count_r  <= fcfl_pkg::RST_CHUNK_COUNT;
      chunk_bytes_r  <= fcfl_pkg::RST_CHUNK_BYTES;
      base_address_r <= fcfl_pkg::RST_BASE_ADDRESS;
      freed_head_r   <= '0;
      freed_valid_r  <= 1'b0;
      fresh_mark_r   <= '0;
      in_use_r       <= '0;
      pop_r          <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          fcfl_pkg::CFG_CHUNK_COUNT:  chunk_count_r  <= cfg_data[CNT_W-1:0];
          fcfl_pkg::CFG_CHUNK_BYTES:  chunk_bytes_r  <= cfg_data[fcfl_pkg::BYTES_W-1:0];
          fcfl_pkg::CFG_BASE_ADDRESS: base_address_r <= cfg_data[fcfl_pkg::ADDR_W-1:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        freed_head_r  <= freed_head_nxt;
        freed_valid_r <= freed_valid_nxt;
        fresh_mark_r  <= fresh_mark_nxt;
        in_use_r      <= in_use_nxt;
        pop_r         <= pop;
      end else if (cmd.finish && pop_r) begin
        freed_head_r <= ram_rdata;
      end
    end
  end

  // per-request products and result register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      g_index_r    <= g_index;
      granted_r    <= granted;
      status_r     <= status;
      addr_prod_r  <= g_index * chunk_bytes_r;
      bytes_prod_r <= bytes_full[fcfl_pkg::USE_BYTES_W-1:0];
    end
    if (cmd.finish) begin
      res_index_r  <= g_index_r;
      res_addr_r   <= granted_r
                    ? base_address_r + fcfl_pkg::ADDR_W'(addr_prod_r) : '0;
      res_status_r <= status_r;
      res_chunks_r <= in_use_r;
      res_bytes_r  <= bytes_prod_r;
    end
  end

  assign out_granted_index   = res_index_r;
  assign out_granted_address = res_addr_r;
  assign out_status          = res_status_r;
  assign out_chunks_in_use   = res_chunks_r;
  assign out_bytes_in_use    = res_bytes_r;

endmodule

// File: rtl/fixed_chunk_free_list_allocator.sv
// ----------------------------------------------------------------------------
// fixed_chunk_free_list_allocator
// Pool allocator of equal-size chunks with a last-in-first-out free list.
//
//   channel  dir  handshake      payload
//   in_if    in   valid/ready    opcode, chunk_index
//   out_if   out  valid/ready    granted_index, granted_address, status,
//                                chunks_in_use, bytes_in_use
//   cfg_if   in   valid/ready    index, data (always ready)
//
// Each request has an accept step and a finish step: the accept cycle updates
// the list and issues the link memory read for a pop, the finish step takes
// the new head from the link memory read port and loads the result register.
// The next request is accepted while a result still waits in that register.
// A stalled result holds the controller in its finish state.
// Reset (synchronous, active low) empties the list; the link memory is
// not cleared.
// ----------------------------------------------------------------------------
module fixed_chunk_free_list_allocator (
  input  logic        clk,
  input  logic        rst_n,
  fcfl_in_if.sink     in_if,
  fcfl_out_if.source  out_if,
  fcfl_cfg_if.sink    cfg_if
);

  fcfl_pkg::cmd_t cmd;

  assign cfg_if.ready = 1'b1;

  fcfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd)
  );

  fcfl_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_opcode           (in_if.opcode),
    .in_chunk_index      (in_if.chunk_index),
    .cfg_we              (cfg_if.valid && cfg_if.ready),
    .cfg_index           (cfg_if.index),
    .cfg_data            (cfg_if.data),
    .out_granted_index   (out_if.granted_index),
    .out_granted_address (out_if.granted_address),
    .out_status          (out_if.status),
    .out_chunks_in_use   (out_if.chunks_in_use),
    .out_bytes_in_use    (out_if.bytes_in_use)
  );

  // a request is never taken in the cycle its predecessor finishes
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.accept && cmd.finish))
    else $error("accept and finish in the same cycle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> !in_if.ready)
    else $error("ready while a request is in flight");

  a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_if.valid) |-> $past(cmd.finish))
    else $error("result shown without a finished request");

  a_no_grant_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (out_if.status != fcfl_pkg::ST_OK)
      |-> (out_if.granted_index == '0) && (out_if.granted_address == '0))
    else $error("grant fields set on a failed request");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.chunks_in_use <= fcfl_pkg::CNT_W'(fcfl_pkg::MAX_CHUNKS)))
    else $error("chunks in use above capacity");

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fixed-chunk free-list allocator. A directed
// table walks reset values, pool size and address extremes, error statuses
// and the unused opcode, then random phases run mostly allocate/free
// traffic under changing pool settings and idle patterns. Every result is
// checked field by field against the table's expected values or an in-bench model of the free list.
// ----------------------------------------------------------------------------
module tb_top;
  import fcfl_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 400000;
  localparam int LONG_STALL   = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 80;
  localparam int PRINT_CAP    = 100;

  typedef struct packed {
    logic [IDX_W-1:0]       granted_index;
    logic [ADDR_W-1:0]      granted_address;
    logic [STATUS_W-1:0]    status;
    logic [CNT_W-1:0]       chunks_in_use;
    logic [USE_BYTES_W-1:0] bytes_in_use;
  } grant_t;

  typedef struct packed {
    logic              is_cfg;
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  idx;
    logic [31:0]       cfg_count;
    logic [31:0]       cfg_bytes;
    logic [31:0]       cfg_base;
    logic              typed;
    grant_t            want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  fcfl_in_if  in_if ();
  fcfl_out_if out_if ();
  fcfl_cfg_if cfg_if ();

  fixed_chunk_free_list_allocator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // model of the pool
  logic [IDX_W-1:0]   link_mem [MAX_CHUNKS];
  logic [IDX_W-1:0]   stack_top;
  logic               stack_live;
  logic [CNT_W-1:0]   fresh_next;
  logic [CNT_W-1:0]   used_chunks;
  logic [CNT_W-1:0]   pool_count;
  logic [BYTES_W-1:0] chunk_size;
  logic [ADDR_W-1:0]  pool_base;

  grant_t           expected_grants [$];
  logic [IDX_W-1:0] held_chunks [$];

  int mismatch_count = 0;
  int results_checked = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic reset_pool_model();
    foreach (link_mem[i]) link_mem[i] = '0;
    stack_top   = '0;
    stack_live  = 1'b0;
    fresh_next  = '0;
    used_chunks = '0;
    pool_count  = RST_CHUNK_COUNT;
    chunk_size  = RST_CHUNK_BYTES;
    pool_base   = RST_BASE_ADDRESS;
  endtask

  function automatic grant_t predict_grant(input logic [OP_W-1:0] op,
                                           input logic [IDX_W-1:0] idx);
    grant_t           r;
    logic             granted;
    logic [CNT_W-1:0] pool;
    logic [63:0]      use_bytes;
    r = '0;
    granted = 1'b0;
    pool = (pool_count > CNT_W'(MAX_CHUNKS)) ? CNT_W'(MAX_CHUNKS) : pool_count;
    case (op)
      OP_ALLOC: begin
        if (stack_live) begin
          r.granted_index = stack_top;
          stack_top = link_mem[stack_top];
          granted = 1'b1;
        end else if (fresh_next < pool) begin
          r.granted_index = fresh_next[IDX_W-1:0];
          fresh_next = fresh_next + 1'b1;
          granted = 1'b1;
        end
        if (granted) begin
          if (used_chunks < CNT_W'(MAX_CHUNKS)) used_chunks = used_chunks + 1'b1;
          stack_live = stack_live && (fresh_next > used_chunks);
          r.granted_address = pool_base + ADDR_W'(r.granted_index) * ADDR_W'(chunk_size);
        end else begin
          r.status = ST_NO_CHUNK;
        end
      end
      OP_FREE: begin
        if (used_chunks == '0) begin
          r.status = ST_FREE_EMPTY;
        end else begin
          link_mem[idx] = stack_top;
          stack_top = idx;
          stack_live = 1'b1;
          used_chunks = used_chunks - 1'b1;
        end
      end
      OP_FREE_ALL: begin
        stack_top   = '0;
        stack_live  = 1'b0;
        fresh_next  = '0;
        used_chunks = '0;
      end
      default: ;
    endcase
    use_bytes = 64'(used_chunks) * 64'(chunk_size);
    r.chunks_in_use = used_chunks;
    r.bytes_in_use = use_bytes[USE_BYTES_W-1:0];
    return r;
  endfunction

  function automatic stim_row_t plain_row(input logic [OP_W-1:0] op,
                                          input logic [IDX_W-1:0] idx);
    stim_row_t row;
    row = '0;
    row.op = op;
    row.idx = idx;
    return row;
  endfunction

  function automatic stim_row_t checked_row(input logic [OP_W-1:0] op,
                                            input logic [IDX_W-1:0] idx,
                                            input logic [IDX_W-1:0] gi,
                                            input logic [ADDR_W-1:0] ga,
                                            input logic [STATUS_W-1:0] st,
                                            input logic [CNT_W-1:0] cu,
                                            input logic [USE_BYTES_W-1:0] bu);
    stim_row_t row;
    row = plain_row(op, idx);
    row.typed = 1'b1;
    row.want = '{gi, ga, st, cu, bu};
    return row;
  endfunction

  function automatic stim_row_t pool_row(input logic [31:0] count_v,
                                         input logic [31:0] bytes_v,
                                         input logic [31:0] base_v);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.cfg_count = count_v;
    row.cfg_bytes = bytes_v;
    row.cfg_base = base_v;
    return row;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("mismatch on result %0d, %s: got 0x%0h, want 0x%0h",
               results_checked, field, got, want);
  endtask

  // wait for every outstanding result, then let the pipeline settle
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic config_pool(input logic [31:0] count_v, input logic [31:0] bytes_v,
                             input logic [31:0] base_v);
    cfg_reg_t    regs [3];
    logic [31:0] vals [3];
    regs = '{CFG_CHUNK_COUNT, CFG_CHUNK_BYTES, CFG_BASE_ADDRESS};
    vals = '{count_v, bytes_v, base_v};
    drain_results();
    for (int i = 0; i < 3; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= regs[i];
      cfg_if.data  <= vals[i];
      do @(posedge clk); while (!cfg_if.ready);
      case (regs[i])
        CFG_CHUNK_COUNT:  pool_count = vals[i][CNT_W-1:0];
        CFG_CHUNK_BYTES:  chunk_size = vals[i][BYTES_W-1:0];
        CFG_BASE_ADDRESS: pool_base  = vals[i];
        default: ;
      endcase
    end
    cfg_if.valid <= 1'b0;
  endtask

  // requests are accepted in order, so predicting when offered is the same
  // as predicting at acceptance
  task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                              input logic typed, input grant_t want);
    grant_t pred;
    pred = predict_grant(op, idx);
    if (op == OP_ALLOC && pred.status == ST_OK) held_chunks.push_back(pred.granted_index);
    if (op == OP_FREE_ALL) held_chunks.delete();
    expected_grants.push_back(typed ? want : pred);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.opcode      <= op;
    in_if.chunk_index <= idx;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // mostly alloc and free of held chunks, the rest stray frees and others
  task automatic random_request();
    int               r;
    int               k;
    logic [IDX_W-1:0] idx;
    r = $urandom_range(99);
    idx = IDX_W'($urandom());
    if (r < 38 && held_chunks.size() > 0) begin
      k = $urandom_range(held_chunks.size() - 1);
      idx = held_chunks[k];
      held_chunks.delete(k);
      send_request(OP_FREE, idx, 1'b0, '0);
    end else if (r < 46) begin
      send_request(OP_FREE, idx, 1'b0, '0);
    end else if (r < 48) begin
      send_request(OP_FREE_ALL, idx, 1'b0, '0);
    end else if (r < 50) begin
      send_request(OP_UNUSED, idx, 1'b0, '0);
    end else begin
      send_request(OP_ALLOC, idx, 1'b0, '0);
    end
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      stall_left = LONG_STALL;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : watch_results
    grant_t want;
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end else if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_grants.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_if.granted_index), '0);
      end else begin
        want = expected_grants.pop_front();
        if (out_if.granted_index !== want.granted_index)
          report_mismatch("granted_index", 32'(out_if.granted_index),
                          32'(want.granted_index));
        if (out_if.granted_address !== want.granted_address)
          report_mismatch("granted_address", out_if.granted_address,
                          want.granted_address);
        if (out_if.status !== want.status)
          report_mismatch("status", 32'(out_if.status), 32'(want.status));
        if (out_if.chunks_in_use !== want.chunks_in_use)
          report_mismatch("chunks_in_use", 32'(out_if.chunks_in_use),
                          32'(want.chunks_in_use));
        if (out_if.bytes_in_use !== want.bytes_in_use)
          report_mismatch("bytes_in_use", 32'(out_if.bytes_in_use),
                          32'(want.bytes_in_use));
      end
      results_checked++;
    end
  end

  initial begin
    stim_row_t   directed_rows [];
    logic [31:0] p_count;
    logic [31:0] p_bytes;
    logic [31:0] p_base;
    int          mode;
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.opcode       = OP_ALLOC;
    in_if.chunk_index  = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = CFG_CHUNK_COUNT;
    cfg_if.data        = '0;
    out_if.ready       = 1'b0;
    reset_pool_model();

    directed_rows = '{
      // freeing before anything is allocated
      checked_row(OP_FREE, 10'd5, '0, '0, ST_FREE_EMPTY, '0, '0),
      checked_row(OP_ALLOC, '0, 10'd0, 32'd0, ST_OK, 11'd1, 27'd64),
      checked_row(OP_ALLOC, '0, 10'd1, 32'd64, ST_OK, 11'd2, 27'd128),
      checked_row(OP_FREE, 10'd0, '0, '0, ST_OK, 11'd1, 27'd64),
      checked_row(OP_ALLOC, 10'h3ff, 10'd0, 32'd0, ST_OK, 11'd2, 27'd128),
      checked_row(OP_UNUSED, 10'h3ff, '0, '0, ST_OK, 11'd2, 27'd128),
      // chunk that was never handed out
      checked_row(OP_FREE, 10'h3ff, '0, '0, ST_OK, 11'd1, 27'd64),
      checked_row(OP_ALLOC, '0, 10'h3ff, 32'd65472, ST_OK, 11'd2, 27'd128),
      checked_row(OP_FREE_ALL, 10'h3ff, '0, '0, ST_OK, '0, '0),
      checked_row(OP_ALLOC, '0, 10'd0, 32'd0, ST_OK, 11'd1, 27'd64),
      // empty pool
      pool_row(32'd0, 32'd64, 32'd0),
      checked_row(OP_FREE_ALL, '0, '0, '0, ST_OK, '0, '0),
      checked_row(OP_ALLOC, '0, '0, '0, ST_NO_CHUNK, '0, '0),
      pool_row(32'd1, 32'd65536, 32'hffff_ffff),
      checked_row(OP_ALLOC, '0, 10'd0, 32'hffff_ffff, ST_OK, 11'd1, 27'd65536),
      checked_row(OP_ALLOC, '0, '0, '0, ST_NO_CHUNK, 11'd1, 27'd65536),
      checked_row(OP_FREE, 10'd0, '0, '0, ST_OK, '0, '0),
      checked_row(OP_ALLOC, '0, 10'd0, 32'hffff_ffff, ST_OK, 11'd1, 27'd65536),
      plain_row(OP_FREE, 10'h2aa),
      plain_row(OP_ALLOC, '0),
      // count above the built capacity
      pool_row(32'd2047, 32'd8, 32'h8000_0000),
      checked_row(OP_FREE_ALL, '0, '0, '0, ST_OK, '0, '0),
      checked_row(OP_ALLOC, '0, 10'd0, 32'h8000_0000, ST_OK, 11'd1, 27'd8),
      plain_row(OP_FREE, 10'h155),
      plain_row(OP_ALLOC, '0),
      plain_row(OP_ALLOC, '0)
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        config_pool(directed_rows[i].cfg_count, directed_rows[i].cfg_bytes,
                    directed_rows[i].cfg_base);
      end else begin
        send_request(directed_rows[i].op, directed_rows[i].idx,
                     directed_rows[i].typed, directed_rows[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin p_count = 32'd4;    p_bytes = 32'd8;      p_base = 32'd0;        end
        1: begin p_count = 32'd16;   p_bytes = 32'd65536;  p_base = 32'hffff_ffff; end
        2: begin p_count = 32'd1;    p_bytes = 32'd100;    p_base = $urandom();   end
        3: begin p_count = 32'd1024; p_bytes = 32'd64;     p_base = 32'hffff_0000; end
        4: begin p_count = 32'd8;    p_bytes = $urandom_range(8, 65536);
                 p_base = $urandom(); end
        5: begin p_count = 32'd2047; p_bytes = 32'h1ffff;  p_base = 32'd0;        end
        6: begin p_count = 32'd33;   p_bytes = 32'd0;      p_base = 32'h1234_5678; end
        default: begin p_count = $urandom_range(1, 64); p_bytes = $urandom_range(8, 4096);
                 p_base = $urandom(); end
      endcase
      config_pool(p_count, p_bytes, p_base);
      mode = ph % 4;
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 61; end
        default: begin send_idle_pct = 18; recv_stall_pct <= 18; end
      endcase
      // long receiver hold-off while requests keep coming
      if (mode == 0) hold_seq <= hold_seq + 1;
      if ($urandom_range(1)) send_request(OP_FREE_ALL, IDX_W'($urandom()), 1'b0, '0);
      for (int n = 0; n < PHASE_ITEMS; n++) random_request();
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
